>>> hw/rtl/tlbpt_pkg.sv
// Shared types, constants and a helper function for the TLB address translator.
package tlbpt_pkg;

  localparam int VA_W  = 16;
  localparam int CNT_W = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_RESOLVE
  } state_t;

  typedef logic [CNT_W-1:0] count_t;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

endpackage

>>> hw/rtl/tlbpt_if.sv
// Valid/ready channel interfaces for the translator input and result transactions.
interface tlbpt_in_if;
  logic                       valid;
  logic                       ready;
  logic [tlbpt_pkg::VA_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlbpt_pkg::VA_W-1:0]  physical_address;
  logic                        tlb_hit;
  logic                        page_fault;
  logic [tlbpt_pkg::CNT_W-1:0] access_count;
  logic [tlbpt_pkg::CNT_W-1:0] tlb_miss_count;
  logic [tlbpt_pkg::CNT_W-1:0] fault_count;

  modport source (output valid, output physical_address, output tlb_hit, output page_fault,
                  output access_count, output tlb_miss_count, output fault_count,
                  input ready);
  modport sink   (input valid, input physical_address, input tlb_hit, input page_fault,
                  input access_count, input tlb_miss_count, input fault_count,
                  output ready);
endinterface

>>> hw/rtl/tlb_page_table_translate_core.sv
// Top level: address translator with a shifting FIFO TLB cell chain and a page table memory.
// Result path: the accepted page is registered, looked up in the TLB cells and page table
// (lookup), then resolved into the result register; a new input is taken only back in idle.
// Resolve holds while the result register is still full.
// Reset: clears TLB valid bits and counters, then sweeps all PAGE_COUNT page table entries
// (256 by default); in_chan.ready stays low until the sweep has ended.
module tlb_page_table_translate_core #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  tlbpt_in_if.sink      in_chan,
  tlbpt_out_if.source   out_chan
);

  import tlbpt_pkg::*;

  localparam int PAGE_W    = $clog2(PAGE_COUNT);
  localparam int VPN_W     = (OFFSET_BITS < VA_W) ? VA_W - OFFSET_BITS : 1;
  localparam int MOD_W     = VPN_W + 1;
  localparam int MOD_STEPS = (VPN_W >= PAGE_W) ? VPN_W - PAGE_W + 1 : 0;

  state_t state_r, state_nxt;

  logic [VPN_W-1:0]       vpn;
  logic [MOD_W-1:0]       mod_rem;
  logic [PAGE_W-1:0]      page_r;
  logic [OFFSET_BITS-1:0] offset_r;

  logic              cell_valid     [TLB_ENTRIES+1];
  logic [PAGE_W-1:0] cell_tag       [TLB_ENTRIES+1];
  logic [PAGE_W-1:0] cell_frame     [TLB_ENTRIES+1];
  logic [PAGE_W-1:0] cell_hit_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] hit_vec;

  logic              hit_any;
  logic [PAGE_W-1:0] hit_frame;
  logic              pt_rd_valid;
  logic [PAGE_W-1:0] pt_rd_frame;
  logic              pt_wr_en;
  logic              pt_clr_busy;
  logic [PAGE_W-1:0] fill_frame;
  logic [PAGE_W-1:0] res_frame;
  logic              fault;
  logic              shift_en;

  logic   in_ready;
  logic   out_free;
  logic   fire;
  count_t acc_r, miss_r, fault_r;
  count_t acc_nxt, miss_nxt, fault_nxt;

  logic              out_valid_r;
  logic [VA_W-1:0]   out_pa_r;
  logic              out_hit_r;
  logic              out_fault_r;
  count_t            out_acc_r, out_miss_r, out_fault_cnt_r;

  // page number reduction modulo PAGE_COUNT by compare-subtract of shifted constants
  assign vpn = VPN_W'(in_chan.virtual_address >> OFFSET_BITS);

  always_comb begin
    mod_rem = {1'b0, vpn};
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      if (mod_rem >= MOD_W'(PAGE_COUNT << j)) begin
        mod_rem = mod_rem - MOD_W'(PAGE_COUNT << j);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (!pt_clr_busy) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_chan.valid) state_nxt = ST_LOOK;
      ST_LOOK:    state_nxt = ST_RESOLVE;
      ST_RESOLVE: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    fire     = 1'b0;
    unique case (state_r)
      ST_CLEAR:   ;
      ST_IDLE:    in_ready = 1'b1;
      ST_LOOK:    ;
      ST_RESOLVE: fire = out_free;
      default:    ;
    endcase
  end

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      page_r   <= PAGE_W'(mod_rem);
      offset_r <= in_chan.virtual_address[OFFSET_BITS-1:0];
    end
  end

  // cell chain: new entries enter at the head, the oldest drops off the tail
  assign cell_valid[0] = 1'b1;
  assign cell_tag[0]   = page_r;
  assign cell_frame[0] = fill_frame;

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    tlbpt_cell #(
      .PAGE_W(PAGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .prev_valid (cell_valid[g]),
      .prev_tag   (cell_tag[g]),
      .prev_frame (cell_frame[g]),
      .look_page  (page_r),
      .valid      (cell_valid[g+1]),
      .tag        (cell_tag[g+1]),
      .frame      (cell_frame[g+1]),
      .hit        (hit_vec[g]),
      .hit_frame  (cell_hit_frame[g])
    );
  end

  always_comb begin
    hit_frame = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      hit_frame = hit_frame | cell_hit_frame[k];
    end
  end

  assign hit_any = |hit_vec;

  tlbpt_page_table #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_W     (PAGE_W)
  ) u_page_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (page_r),
    .rd_valid (pt_rd_valid),
    .rd_frame (pt_rd_frame),
    .wr_en    (pt_wr_en),
    .wr_addr  (page_r),
    .wr_frame (page_r),
    .clr_busy (pt_clr_busy)
  );

  always_comb begin
    fault      = !hit_any && !pt_rd_valid;
    fill_frame = pt_rd_valid ? pt_rd_frame : page_r;
    res_frame  = hit_any ? hit_frame : fill_frame;
    shift_en   = fire && !hit_any;
    pt_wr_en   = fire && fault;
    acc_nxt    = sat_inc(acc_r);
    miss_nxt   = hit_any ? miss_r : sat_inc(miss_r);
    fault_nxt  = fault ? sat_inc(fault_r) : fault_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      miss_r      <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      acc_r       <= acc_nxt;
      miss_r      <= miss_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pa_r        <= VA_W'({res_frame, offset_r});
      out_hit_r       <= hit_any;
      out_fault_r     <= fault;
      out_acc_r       <= acc_nxt;
      out_miss_r      <= miss_nxt;
      out_fault_cnt_r <= fault_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.physical_address = out_pa_r;
  assign out_chan.tlb_hit          = out_hit_r;
  assign out_chan.page_fault       = out_fault_r;
  assign out_chan.access_count     = out_acc_r;
  assign out_chan.tlb_miss_count   = out_miss_r;
  assign out_chan.fault_count      = out_fault_cnt_r;

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> $onehot0(hit_vec))
    else $error("more than one TLB cell matched the page");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pt_clr_busy |-> !in_chan.ready)
    else $error("input accepted during page table sweep");

  a_fault_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.tlb_hit && out_chan.page_fault))
    else $error("fault reported on a TLB hit");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.access_count >= out_chan.tlb_miss_count) &&
                       (out_chan.tlb_miss_count >= out_chan.fault_count))
    else $error("counter ordering broken");

  a_fill_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> cell_valid[1] && (cell_tag[1] == $past(page_r)))
    else $error("TLB head cell not filled after miss");
`endif

endmodule

>>> hw/rtl/tlbpt_cell.sv
// One TLB entry cell: holds an entry, shifts it to the next cell on fill, matches a page.
module tlbpt_cell #(
  parameter int PAGE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic              prev_valid,
  input  logic [PAGE_W-1:0] prev_tag,
  input  logic [PAGE_W-1:0] prev_frame,
  input  logic [PAGE_W-1:0] look_page,
  output logic              valid,
  output logic [PAGE_W-1:0] tag,
  output logic [PAGE_W-1:0] frame,
  output logic              hit,
  output logic [PAGE_W-1:0] hit_frame
);

  logic              valid_r;
  logic [PAGE_W-1:0] tag_r;
  logic [PAGE_W-1:0] frame_r;
  logic              hit_r;
  logic [PAGE_W-1:0] hit_frame_r;
  logic              match;

  assign match = valid_r && (tag_r == look_page);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      hit_r <= match;
      if (shift_en) begin
        valid_r <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_frame_r <= match ? frame_r : '0;
    if (shift_en) begin
      tag_r   <= prev_tag;
      frame_r <= prev_frame;
    end
  end

  assign valid     = valid_r;
  assign tag       = tag_r;
  assign frame     = frame_r;
  assign hit       = hit_r;
  assign hit_frame = hit_frame_r;

endmodule

>>> hw/rtl/tlbpt_page_table.sv
// Page table memory of valid bit and frame per page, with a clearing sweep after reset.
module tlbpt_page_table #(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_W     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] rd_addr,
  output logic              rd_valid,
  output logic [PAGE_W-1:0] rd_frame,
  input  logic              wr_en,
  input  logic [PAGE_W-1:0] wr_addr,
  input  logic [PAGE_W-1:0] wr_frame,
  output logic              clr_busy
);

  logic [PAGE_W:0]   mem [PAGE_COUNT];
  logic [PAGE_W:0]   rd_data_r;
  logic              clr_busy_r;
  logic [PAGE_W-1:0] clr_idx_r;
  logic              mem_we;
  logic [PAGE_W-1:0] mem_waddr;
  logic [PAGE_W:0]   mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == PAGE_W'(PAGE_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we    = clr_busy_r || wr_en;
    mem_waddr = clr_busy_r ? clr_idx_r : wr_addr;
    mem_wdata = clr_busy_r ? '0 : {1'b1, wr_frame};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_valid = rd_data_r[PAGE_W];
  assign rd_frame = rd_data_r[PAGE_W-1:0];
  assign clr_busy = clr_busy_r;

endmodule

>>> tb/tb_tlb_page_table_translate_core.sv
// Self-checking testbench for the TLB/page-table address translator core.
module tb_tlb_page_table_translate_core;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int OFFSET_BITS = 8;
  localparam int VA_W        = tlbpt_pkg::VA_W;
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int RANDOM_ITEMS = 1826;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    logic [VA_W-1:0]   physical_address;
    logic              tlb_hit;
    logic              page_fault;
    tlbpt_pkg::count_t access_count;
    tlbpt_pkg::count_t tlb_miss_count;
    tlbpt_pkg::count_t fault_count;
  } xlate_t;

  class translation_tracker;
    logic [PAGE_W-1:0] tlb_tag [TLB_ENTRIES];
    logic [PAGE_W-1:0] tlb_frame [TLB_ENTRIES];
    bit                tlb_valid [TLB_ENTRIES];
    int                fill_slot;
    bit                table_valid [PAGE_COUNT];
    logic [PAGE_W-1:0] table_frame [PAGE_COUNT];
    tlbpt_pkg::count_t accesses;
    tlbpt_pkg::count_t misses;
    tlbpt_pkg::count_t faults;
    xlate_t            pending_xlates [$];
    int                errors;

    function new();
      foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
      foreach (table_valid[i]) table_valid[i] = 1'b0;
      fill_slot = 0;
      accesses  = '0;
      misses    = '0;
      faults    = '0;
      errors    = 0;
    endfunction

    function tlbpt_pkg::count_t bump(tlbpt_pkg::count_t v);
      return (v == '1) ? v : v + 1;
    endfunction

    function void note_address(logic [VA_W-1:0] va);
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] frame;
      int                pa_full;
      bit                hit;
      bit                fault;
      xlate_t            r;
      page  = PAGE_W'(va >> OFFSET_BITS);
      frame = '0;
      hit   = 1'b0;
      fault = 1'b0;
      accesses = bump(accesses);
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (!hit && tlb_valid[i] && tlb_tag[i] == page) begin
          frame = tlb_frame[i];
          hit   = 1'b1;
        end
      end
      if (!hit) begin
        misses = bump(misses);
        if (!table_valid[page]) begin
          table_valid[page] = 1'b1;
          table_frame[page] = page;
          fault  = 1'b1;
          faults = bump(faults);
        end
        frame = table_frame[page];
        tlb_tag[fill_slot]   = page;
        tlb_frame[fill_slot] = frame;
        tlb_valid[fill_slot] = 1'b1;
        fill_slot = (fill_slot + 1) % TLB_ENTRIES;
      end
      pa_full = (int'(frame) << OFFSET_BITS) | (int'(va) & ((1 << OFFSET_BITS) - 1));
      r.physical_address = pa_full[VA_W-1:0];
      r.tlb_hit          = hit;
      r.page_fault       = fault;
      r.access_count     = accesses;
      r.tlb_miss_count   = misses;
      r.fault_count      = faults;
      pending_xlates.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(xlate_t got);
      xlate_t want;
      if (pending_xlates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pa %h hit %b fault %b",
                 $time, got.physical_address, got.tlb_hit, got.page_fault);
        return;
      end
      want = pending_xlates.pop_front();
      compare_field("physical_address", 32'(want.physical_address), 32'(got.physical_address));
      compare_field("tlb_hit", 32'(want.tlb_hit), 32'(got.tlb_hit));
      compare_field("page_fault", 32'(want.page_fault), 32'(got.page_fault));
      compare_field("access_count", want.access_count, got.access_count);
      compare_field("tlb_miss_count", want.tlb_miss_count, got.tlb_miss_count);
      compare_field("fault_count", want.fault_count, got.fault_count);
    endfunction

    function int pending();
      return pending_xlates.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tlbpt_in_if  in_ch ();
  tlbpt_out_if out_ch ();

  tlb_page_table_translate_core #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  translation_tracker tracker = new();
  logic [VA_W-1:0]    addr_list [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_address(in_ch.virtual_address);
  end

  always @(posedge clk) begin
    xlate_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.physical_address = out_ch.physical_address;
      got.tlb_hit          = out_ch.tlb_hit;
      got.page_fault       = out_ch.page_fault;
      got.access_count     = out_ch.access_count;
      got.tlb_miss_count   = out_ch.tlb_miss_count;
      got.fault_count      = out_ch.fault_count;
      tracker.check_result(got);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: stall pattern of its own, with one long hold-off early on.
  initial begin
    int seg;
    int len;
    int mode;
    out_ch.ready <= 1'b0;
    seg = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg == 4) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 60);
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
            repeat (len) @(posedge clk);
          end
          1: begin
            repeat (len) begin
              out_ch.ready <= 1'($urandom_range(0, 1));
              @(posedge clk);
            end
          end
          2: begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
          end
          default: begin
            repeat (len) begin
              out_ch.ready <= ~out_ch.ready;
              @(posedge clk);
            end
          end
        endcase
      end
      seg++;
    end
  end

  task automatic drive_address(input logic [VA_W-1:0] va);
    in_ch.valid           <= 1'b1;
    in_ch.virtual_address <= va;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int idx;
    int burst;
    int gap;
    int base;
    int span;
    logic [PAGE_W-1:0] page;

    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.virtual_address <= '0;

    // Faults at the extremes, hits on the same page, TLB wrap and refill from the table.
    addr_list.push_back(16'h0000);
    addr_list.push_back(16'h00FF);
    addr_list.push_back(16'hFFFF);
    addr_list.push_back(16'hFF00);
    for (int p = 1; p <= 15; p++)
      addr_list.push_back({8'(p), 8'($urandom)});
    addr_list.push_back(16'h0012);
    addr_list.push_back(16'hFFAB);
    addr_list.push_back(16'h0F80);
    addr_list.push_back(16'h8000);
    addr_list.push_back(16'h7FFF);

    base = 0;
    span = 4;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        base = $urandom_range(0, PAGE_COUNT - 1);
        span = $urandom_range(4, 40);
      end
      if ($urandom_range(0, 9) < 7) begin
        page = PAGE_W'(base + $urandom_range(0, span - 1));
        addr_list.push_back({page, 8'($urandom)});
      end else begin
        addr_list.push_back(VA_W'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < addr_list.size()) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && idx < addr_list.size(); b++) begin
        drive_address(addr_list[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (tracker.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (tracker.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_if.sv
hw/rtl/tlbpt_cell.sv
hw/rtl/tlbpt_page_table.sv
hw/rtl/tlb_page_table_translate_core.sv
tb/tb_tlb_page_table_translate_core.sv
